// File: src/mtm_pkg.sv
// Shared constants and types for the model transform matrix block.
// Used by mtm_horner, mtm_trig, mtm_rows and model_transform_matrix.
`default_nettype none
package mtm_pkg;

	localparam int FULL_TURN = 23040;
	localparam int OCTANT    = 2880;
	localparam logic [18:0] RAD_STEP = 19'd292818;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [31:0] ONE_Q16  = 32'd65536;

	// trig pipeline depth, angle in to sine/cosine out
	localparam int TRIG_LAT = 14;

	// exact reciprocal multipliers for x < 2^30: x / d == (x * M) >> K
	localparam int K72 = 37;
	localparam int K42 = 36;
	localparam int K20 = 35;
	localparam int K6  = 33;
	localparam int K56 = 36;
	localparam int K30 = 35;
	localparam int K12 = 34;
	localparam int K2  = 31;
	localparam longint M72L = ((64'd1 << K72) + 64'd71) / 64'd72;
	localparam longint M42L = ((64'd1 << K42) + 64'd41) / 64'd42;
	localparam longint M20L = ((64'd1 << K20) + 64'd19) / 64'd20;
	localparam longint M6L  = ((64'd1 << K6)  + 64'd5)  / 64'd6;
	localparam longint M56L = ((64'd1 << K56) + 64'd55) / 64'd56;
	localparam longint M30L = ((64'd1 << K30) + 64'd29) / 64'd30;
	localparam longint M12L = ((64'd1 << K12) + 64'd11) / 64'd12;
	localparam longint M2L  = ((64'd1 << K2)  + 64'd1)  / 64'd2;

	typedef logic signed [15:0] trig_t;
	typedef logic signed [30:0] q28_t;
	typedef logic signed [31:0] q16_t;

	// pose payload that rides alongside the trig pipeline
	typedef struct packed {
		q16_t [2:0] scl;
		q16_t [2:0] tr;
	} pose_t;

	// one finished rotation block with its scales and translations
	typedef struct packed {
		q28_t [8:0] rot;
		q16_t [2:0] scl;
		q16_t [2:0] tr;
	} mat_t;

endpackage
`default_nettype wire

// File: src/model_transform_matrix.sv
// Top level: pose in, four matrix rows out (T * Rx * Ry * Rz * S).
// Uses mtm_pkg, mtm_trig and mtm_rows.
//
//   channel | valid     | stall      | payload
//   pose    | in_valid  | in_stall   | angle_x..z, scale_x..z, shift_x..z
//   row     | out_valid | out_stall  | row_index, entry_0..3, last_row
//
// A pose passes the trig pipeline and stages 15 to 17 to the row emitter,
// which sends its four rows through one output register, one per cycle
// while out_stall is low, and takes the next pose as the last row moves on.
// Reset clears all valid bits; payload registers are not reset.
// A row stall halts the pipeline while stage 17 holds a pose; none is dropped.
`default_nettype none
module model_transform_matrix (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic signed [15:0]  angle_x,
	input  wire logic signed [15:0]  angle_y,
	input  wire logic signed [15:0]  angle_z,
	input  wire mtm_pkg::q16_t       scale_x,
	input  wire mtm_pkg::q16_t       scale_y,
	input  wire mtm_pkg::q16_t       scale_z,
	input  wire mtm_pkg::q16_t       shift_x,
	input  wire mtm_pkg::q16_t       shift_y,
	input  wire mtm_pkg::q16_t       shift_z,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [1:0]               row_index,
	output mtm_pkg::q16_t            entry_0,
	output mtm_pkg::q16_t            entry_1,
	output mtm_pkg::q16_t            entry_2,
	output mtm_pkg::q16_t            entry_3,
	output logic                     last_row
);
	import mtm_pkg::*;

	logic  en;
	logic  v_dly_q [0:TRIG_LAT-1];
	pose_t pose_dly_q [0:TRIG_LAT-1];
	trig_t sx, cx, sy, cy, sz, cz;

	// stage 15: two-factor products
	logic  v_s15;
	pose_t pose_s15;
	logic signed [31:0] cycz_s15, cysz_s15, cxsz_s15, cxcz_s15, sxcy_s15;
	logic signed [31:0] cxcy_s15, sxsz_s15, sxcz_s15, sxsy_s15, cxsy_s15;
	trig_t sy_s15, cz_s15, sz_s15;
	// stage 16: Q42 entries
	logic  v_s16;
	pose_t pose_s16;
	logic signed [45:0] rot_s16 [0:8];
	// stage 17: Q28 entries
	logic  v_s17;
	mat_t  mat_s17;

	logic  up_ready;
	logic signed [45:0] rot_c [0:8];
	pose_t pose_in;

	assign en       = up_ready || !v_s17;
	assign in_stall = !en;

	assign pose_in.scl = {scale_z, scale_y, scale_x};
	assign pose_in.tr  = {shift_z, shift_y, shift_x};

	mtm_trig u_trig_x (.clk, .en, .angle(angle_x), .sin_v(sx), .cos_v(cx));
	mtm_trig u_trig_y (.clk, .en, .angle(angle_y), .sin_v(sy), .cos_v(cy));
	mtm_trig u_trig_z (.clk, .en, .angle(angle_z), .sin_v(sz), .cos_v(cz));

	// combine into Q42 rotation entries
	always_comb begin
		logic signed [47:0] a, b, c, d;
		a = 48'(sxsy_s15) * 48'(cz_s15);
		b = 48'(sxsy_s15) * 48'(sz_s15);
		c = 48'(cxsy_s15) * 48'(cz_s15);
		d = 48'(cxsy_s15) * 48'(sz_s15);
		rot_c[0] = 46'(cycz_s15) <<< 14;
		rot_c[1] = -(46'(cysz_s15) <<< 14);
		rot_c[2] = 46'(sy_s15) <<< 28;
		rot_c[3] = 46'(a) + (46'(cxsz_s15) <<< 14);
		rot_c[4] = -46'(b) + (46'(cxcz_s15) <<< 14);
		rot_c[5] = -(46'(sxcy_s15) <<< 14);
		rot_c[6] = -46'(c) + (46'(sxsz_s15) <<< 14);
		rot_c[7] = 46'(d) + (46'(sxcz_s15) <<< 14);
		rot_c[8] = 46'(cxcy_s15) <<< 14;
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRIG_LAT; i++)
				v_dly_q[i] <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_dly_q[0] <= in_valid;
			for (int i = 1; i < TRIG_LAT; i++)
				v_dly_q[i] <= v_dly_q[i-1];
			v_s15 <= v_dly_q[TRIG_LAT-1];
			v_s16 <= v_s15;
			v_s17 <= v_s16;
		end
	end

	// advance payload
	always_ff @(posedge clk) begin
		if (en) begin
			pose_dly_q[0] <= pose_in;
			for (int i = 1; i < TRIG_LAT; i++)
				pose_dly_q[i] <= pose_dly_q[i-1];
			pose_s15 <= pose_dly_q[TRIG_LAT-1];
			cycz_s15 <= cy * cz;
			cysz_s15 <= cy * sz;
			cxsz_s15 <= cx * sz;
			cxcz_s15 <= cx * cz;
			sxcy_s15 <= sx * cy;
			cxcy_s15 <= cx * cy;
			sxsz_s15 <= sx * sz;
			sxcz_s15 <= sx * cz;
			sxsy_s15 <= sx * sy;
			cxsy_s15 <= cx * sy;
			sy_s15   <= sy;
			cz_s15   <= cz;
			sz_s15   <= sz;
			pose_s16 <= pose_s15;
			for (int i = 0; i < 9; i++)
				rot_s16[i] <= rot_c[i];
			for (int i = 0; i < 9; i++)
				mat_s17.rot[i] <= 31'((rot_s16[i] + 46'sd8192) >>> 14);
			mat_s17.scl <= pose_s16.scl;
			mat_s17.tr  <= pose_s16.tr;
		end
	end

	mtm_rows u_rows (
		.clk, .arst_n,
		.in_v(v_s17), .in_mat(mat_s17), .up_ready,
		.out_valid, .out_stall,
		.row_index, .entry_0, .entry_1, .entry_2, .entry_3, .last_row
	);

endmodule
`default_nettype wire

// File: src/mtm_horner.sv
// One Horner step of the sine/cosine series: 1 - ((t2 * p) >> 30) / d.
// Two register stages; depends on mtm_pkg.
`default_nettype none
module mtm_horner (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [29:0] t2_in,
	input  wire logic [30:0] p_in,
	input  wire logic [30:0] mul_k,
	input  wire logic [5:0]  sh,
	output logic      [29:0] t2_out,
	output logic      [30:0] p_out
);
	import mtm_pkg::*;

	logic [60:0] m_s1;
	logic [29:0] t2_s1;
	logic [60:0] prod_s2;
	logic [29:0] t2_s2;

	// multiply by t2, then by the reciprocal of the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1    <= 61'(t2_in) * 61'(p_in);
			t2_s1   <= t2_in;
			prod_s2 <= 61'(m_s1[59:30]) * 61'(mul_k);
			t2_s2   <= t2_s1;
		end
	end

	assign t2_out = t2_s2;
	assign p_out  = ONE_Q30 - 31'(prod_s2 >> sh);

endmodule
`default_nettype wire

// File: src/mtm_trig.sv
// Pipelined sine/cosine in Q14 of an angle in 1/64 degree steps.
// Octant reduction plus series evaluation; uses mtm_pkg and mtm_horner.
`default_nettype none
module mtm_trig (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic signed [15:0]  angle,
	output mtm_pkg::trig_t           sin_v,
	output mtm_pkg::trig_t           cos_v
);
	import mtm_pkg::*;

	logic [14:0] r_s1;
	logic [2:0]  oct_s2;
	logic [11:0] g_s2;
	logic [29:0] t_s3;
	logic [29:0] t2_s4;
	logic [29:0] t_d_q [0:8];
	logic [2:0]  oct_d_q [0:10];
	logic [29:0] sin_t2 [0:4];
	logic [30:0] sin_p  [0:4];
	logic [29:0] cos_t2 [0:4];
	logic [30:0] cos_p  [0:4];
	logic [29:0] s_s13;
	logic [30:0] c_s13;
	trig_t       sin_s14;
	trig_t       cos_s14;

	logic signed [17:0] a_ext;
	logic [14:0] r_c;
	logic [2:0]  oct_c;
	logic [11:0] f_c;
	logic [59:0] tt_c;
	logic [60:0] tp_c;
	trig_t       s0_c;
	trig_t       c0_c;

	// reduce modulo a full turn
	always_comb begin
		a_ext = 18'(angle);
		if (a_ext < -18'sd23040)
			r_c = 15'(a_ext + 18'sd46080);
		else if (a_ext < 0)
			r_c = 15'(a_ext + 18'sd23040);
		else if (a_ext >= 18'sd23040)
			r_c = 15'(a_ext - 18'sd23040);
		else
			r_c = 15'(a_ext);
	end

	// find octant and offset within it; odd octants mirror it when registered
	always_comb begin
		oct_c = '0;
		for (int k = 1; k < 8; k++) begin
			if (r_s1 >= 15'(k * OCTANT))
				oct_c = 3'(k);
		end
		f_c = 12'(r_s1 - 15'(oct_c) * 15'(OCTANT));
	end

	assign tt_c = 60'(t_s3) * 60'(t_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= r_c;
			oct_s2 <= oct_c;
			g_s2   <= oct_c[0] ? 12'(OCTANT) - f_c : f_c;
			t_s3   <= 30'(30'(g_s2) * 30'(RAD_STEP));
			t2_s4  <= tt_c[59:30];
			t_d_q[0] <= t_s3;
			for (int i = 1; i < 9; i++)
				t_d_q[i] <= t_d_q[i-1];
			oct_d_q[0] <= oct_s2;
			for (int i = 1; i < 11; i++)
				oct_d_q[i] <= oct_d_q[i-1];
		end
	end

	assign sin_t2[0] = t2_s4;
	assign sin_p[0]  = ONE_Q30;
	assign cos_t2[0] = t2_s4;
	assign cos_p[0]  = ONE_Q30;

	// sine series steps
	mtm_horner u_s0 (.clk, .en, .t2_in(sin_t2[0]), .p_in(sin_p[0]),
		.mul_k(31'(M72L)), .sh(6'(K72)), .t2_out(sin_t2[1]), .p_out(sin_p[1]));
	mtm_horner u_s1 (.clk, .en, .t2_in(sin_t2[1]), .p_in(sin_p[1]),
		.mul_k(31'(M42L)), .sh(6'(K42)), .t2_out(sin_t2[2]), .p_out(sin_p[2]));
	mtm_horner u_s2 (.clk, .en, .t2_in(sin_t2[2]), .p_in(sin_p[2]),
		.mul_k(31'(M20L)), .sh(6'(K20)), .t2_out(sin_t2[3]), .p_out(sin_p[3]));
	mtm_horner u_s3 (.clk, .en, .t2_in(sin_t2[3]), .p_in(sin_p[3]),
		.mul_k(31'(M6L)), .sh(6'(K6)), .t2_out(sin_t2[4]), .p_out(sin_p[4]));

	// cosine series steps, last one halves
	mtm_horner u_c0 (.clk, .en, .t2_in(cos_t2[0]), .p_in(cos_p[0]),
		.mul_k(31'(M56L)), .sh(6'(K56)), .t2_out(cos_t2[1]), .p_out(cos_p[1]));
	mtm_horner u_c1 (.clk, .en, .t2_in(cos_t2[1]), .p_in(cos_p[1]),
		.mul_k(31'(M30L)), .sh(6'(K30)), .t2_out(cos_t2[2]), .p_out(cos_p[2]));
	mtm_horner u_c2 (.clk, .en, .t2_in(cos_t2[2]), .p_in(cos_p[2]),
		.mul_k(31'(M12L)), .sh(6'(K12)), .t2_out(cos_t2[3]), .p_out(cos_p[3]));
	mtm_horner u_c3 (.clk, .en, .t2_in(cos_t2[3]), .p_in(cos_p[3]),
		.mul_k(31'(M2L)), .sh(6'(K2)), .t2_out(cos_t2[4]), .p_out(cos_p[4]));

	assign tp_c = 61'(t_d_q[8]) * 61'(sin_p[4]);

	// round to Q14 and fold octant back in
	always_comb begin
		logic [14:0] s;
		logic [14:0] c;
		s = 15'((31'(s_s13) + 31'd32768) >> 16);
		c = 15'((32'(c_s13) + 32'd32768) >> 16);
		s0_c = 16'(s);
		c0_c = 16'(c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s13 <= tp_c[59:30];
			c_s13 <= cos_p[4];
			case (oct_d_q[10])
				3'd0: begin sin_s14 <= s0_c;  cos_s14 <= c0_c;  end
				3'd1: begin sin_s14 <= c0_c;  cos_s14 <= s0_c;  end
				3'd2: begin sin_s14 <= c0_c;  cos_s14 <= -s0_c; end
				3'd3: begin sin_s14 <= s0_c;  cos_s14 <= -c0_c; end
				3'd4: begin sin_s14 <= -s0_c; cos_s14 <= -c0_c; end
				3'd5: begin sin_s14 <= -c0_c; cos_s14 <= -s0_c; end
				3'd6: begin sin_s14 <= -c0_c; cos_s14 <= s0_c;  end
				default: begin sin_s14 <= -s0_c; cos_s14 <= c0_c; end
			endcase
		end
	end

	assign sin_v = sin_s14;
	assign cos_v = cos_s14;

endmodule
`default_nettype wire

// File: src/mtm_rows.sv
// Row emitter: holds one matrix, scales one row per cycle unless the output
// stalls, rounds and saturates into the output register. Depends on mtm_pkg.
`default_nettype none
module mtm_rows (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_v,
	input  wire mtm_pkg::mat_t in_mat,
	output logic               up_ready,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [1:0]         row_index,
	output mtm_pkg::q16_t      entry_0,
	output mtm_pkg::q16_t      entry_1,
	output mtm_pkg::q16_t      entry_2,
	output mtm_pkg::q16_t      entry_3,
	output logic               last_row
);
	import mtm_pkg::*;

	logic        h_v_q;
	mat_t        h_q;
	logic [1:0]  cnt_q;
	logic        r1_v_s1;
	logic [1:0]  r1_row_s1;
	logic signed [62:0] r1_p_s1 [0:2];
	q16_t        r1_tr_s1;
	logic        o_v_s2;
	logic [1:0]  o_row_s2;
	q16_t        o_e_s2 [0:3];

	logic        adv_o;
	logic signed [62:0] p_c [0:2];
	q16_t        sat_c [0:2];

	assign adv_o    = !o_v_s2 || !out_stall;
	assign up_ready = !h_v_q || (adv_o && cnt_q == 2'd3);

	// scale the current row's rotation entries
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (cnt_q == 2'd3)
				p_c[j] = '0;
			else
				p_c[j] = 63'($signed(h_q.rot[cnt_q * 3 + j])) * 63'($signed(h_q.scl[j]));
		end
	end

	// round by 2^28 and clamp to 32 bits
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			logic signed [34:0] v;
			v = 35'((r1_p_s1[j] + 63'sd134217728) >>> 28);
			if (v > 35'sd2147483647)
				sat_c[j] = 32'sh7fff_ffff;
			else if (v < -35'sd2147483648)
				sat_c[j] = 32'sh8000_0000;
			else
				sat_c[j] = 32'(v);
		end
	end

	// hold word, advance row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_v_q   <= 1'b0;
			cnt_q   <= '0;
			r1_v_s1 <= 1'b0;
			o_v_s2  <= 1'b0;
		end else begin
			if (up_ready)
				h_v_q <= in_v;
			if (adv_o) begin
				r1_v_s1 <= h_v_q;
				o_v_s2  <= r1_v_s1;
				if (h_v_q)
					cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready)
			h_q <= in_mat;
		if (adv_o) begin
			r1_row_s1 <= cnt_q;
			for (int j = 0; j < 3; j++)
				r1_p_s1[j] <= p_c[j];
			r1_tr_s1 <= (cnt_q == 2'd3) ? ONE_Q16 : h_q.tr[cnt_q];
			o_row_s2 <= r1_row_s1;
			for (int j = 0; j < 3; j++)
				o_e_s2[j] <= sat_c[j];
			o_e_s2[3] <= r1_tr_s1;
		end
	end

	assign out_valid = o_v_s2;
	assign row_index = o_row_s2;
	assign entry_0   = o_e_s2[0];
	assign entry_1   = o_e_s2[1];
	assign entry_2   = o_e_s2[2];
	assign entry_3   = o_e_s2[3];
	assign last_row  = (o_row_s2 == 2'd3);

endmodule
`default_nettype wire

// File: tb/sv/tb_model_transform_matrix.sv
// Testbench for model_transform_matrix: directed and random poses in, rows out,
// four per pose, each checked against a fixed-point predictor of T*Rx*Ry*Rz*S.
// Depends on mtm_pkg and the model_transform_matrix RTL.
`timescale 1ns / 100ps

class matrix_scoreboard;
	typedef struct {
		logic [1:0]  row;
		logic [31:0] e [4];
		logic        last;
	} row_word_t;

	row_word_t pending_rows[$];
	int errors;

	static function longint round_div(longint v, int k);
		longint w;
		w = v + (longint'(1) << (k - 1));
		return w >>> k;
	endfunction

	static function longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// sine and cosine in Q14 from degrees with 6 fraction bits
	static function void sin_cos(int ang, output longint sn, output longint cs);
		int r, oct, f, g;
		longint unsigned t, t2, p, q, s, c;
		longint s0, c0;
		r = ang % mtm_pkg::FULL_TURN;
		if (r < 0)
			r += mtm_pkg::FULL_TURN;
		oct = r / mtm_pkg::OCTANT;
		f = r % mtm_pkg::OCTANT;
		g = oct[0] ? mtm_pkg::OCTANT - f : f;
		t = longint'(g) * 292818;
		t2 = (t * t) >> 30;
		p = (64'd1 << 30) - t2 / 72;
		p = (64'd1 << 30) - ((t2 * p) >> 30) / 42;
		p = (64'd1 << 30) - ((t2 * p) >> 30) / 20;
		p = (64'd1 << 30) - ((t2 * p) >> 30) / 6;
		s = (t * p) >> 30;
		q = (64'd1 << 30) - t2 / 56;
		q = (64'd1 << 30) - ((t2 * q) >> 30) / 30;
		q = (64'd1 << 30) - ((t2 * q) >> 30) / 12;
		c = (64'd1 << 30) - ((t2 * q) >> 30) / 2;
		s0 = longint'((s + 32768) >> 16);
		c0 = longint'((c + 32768) >> 16);
		case (oct)
			0: begin sn = s0;  cs = c0;  end
			1: begin sn = c0;  cs = s0;  end
			2: begin sn = c0;  cs = -s0; end
			3: begin sn = s0;  cs = -c0; end
			4: begin sn = -s0; cs = -c0; end
			5: begin sn = -c0; cs = -s0; end
			6: begin sn = -c0; cs = s0;  end
			default: begin sn = -s0; cs = c0; end
		endcase
	endfunction

	// note an accepted pose: queue its four rows
	function void note_pose(logic signed [15:0] ax, ay, az,
			logic signed [31:0] scl [3], logic signed [31:0] tr [3]);
		longint sx, cx, sy, cy, sz, cz;
		longint rot [3][3];
		row_word_t w;
		sin_cos(ax, sx, cx);
		sin_cos(ay, sy, cy);
		sin_cos(az, sz, cz);
		rot[0][0] = cy * cz * 16384;
		rot[0][1] = -cy * sz * 16384;
		rot[0][2] = sy * 16384 * 16384;
		rot[1][0] = sx * sy * cz + cx * sz * 16384;
		rot[1][1] = -sx * sy * sz + cx * cz * 16384;
		rot[1][2] = -sx * cy * 16384;
		rot[2][0] = -cx * sy * cz + sx * sz * 16384;
		rot[2][1] = cx * sy * sz + sx * cz * 16384;
		rot[2][2] = cx * cy * 16384;
		for (int i = 0; i < 4; i++) begin
			w.row = i[1:0];
			w.last = (i == 3);
			if (i < 3) begin
				for (int j = 0; j < 3; j++)
					w.e[j] = 32'(clamp32(round_div(round_div(rot[i][j], 14)
						* longint'(scl[j]), 28)));
				w.e[3] = tr[i];
			end else begin
				w.e[0] = 0;
				w.e[1] = 0;
				w.e[2] = 0;
				w.e[3] = mtm_pkg::ONE_Q16;
			end
			pending_rows.push_back(w);
		end
	endfunction

	// compare one accepted row with the oldest expectation
	function void check_row(logic [1:0] row, logic [31:0] e [4], logic last);
		row_word_t w;
		bit bad;
		if (pending_rows.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected row %0d", row);
			return;
		end
		w = pending_rows.pop_front();
		bad = (row !== w.row) || (last !== w.last);
		for (int j = 0; j < 4; j++)
			if (e[j] !== w.e[j])
				bad = 1;
		if (bad) begin
			errors++;
			if (errors <= 10)
				$display("row mismatch exp %0d %h %h %h %h %b got %0d %h %h %h %h %b",
					w.row, w.e[0], w.e[1], w.e[2], w.e[3], w.last,
					row, e[0], e[1], e[2], e[3], last);
		end
	endfunction
endclass

module tb_model_transform_matrix;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] angle_x = 0, angle_y = 0, angle_z = 0;
	mtm_pkg::q16_t scale_x = 0, scale_y = 0, scale_z = 0;
	mtm_pkg::q16_t shift_x = 0, shift_y = 0, shift_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] row_index;
	mtm_pkg::q16_t entry_0, entry_1, entry_2, entry_3;
	logic last_row;
	bit stim_done = 0;

	matrix_scoreboard board = new();

	model_transform_matrix dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// random angle, sometimes beyond a full turn, sometimes the field extremes
	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 8) * 2880) - 16'd23040;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	function automatic logic [31:0] pick_q16();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2, 3: return $urandom;
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	// present one pose and hold it until accepted; drop valid only in a gap
	task automatic send_pose(logic [15:0] ax, ay, az, logic [31:0] sc [3],
			logic [31:0] sh [3], int gap);
		logic signed [31:0] scl [3];
		logic signed [31:0] tr [3];
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		scale_x <= sc[0];
		scale_y <= sc[1];
		scale_z <= sc[2];
		shift_x <= sh[0];
		shift_y <= sh[1];
		shift_z <= sh[2];
		do @(posedge clk); while (in_stall);
		foreach (sc[i]) begin
			scl[i] = sc[i];
			tr[i] = sh[i];
		end
		board.note_pose(ax, ay, az, scl, tr);
	endtask

	// drive directed then random poses
	initial begin
		logic [31:0] sc [3];
		logic [31:0] sh [3];
		logic [15:0] a;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// octant boundaries about each axis, unit scale
		for (int k = 0; k < 9; k++) begin
			a = 16'(k * 2880);
			sc = '{32'h10000, 32'h10000, 32'h10000};
			sh = '{32'h7fffffff, 32'h80000000, 32'h0};
			send_pose(a, -a, k[0] ? a : 16'h0, sc, sh, 0);
		end
		// field extremes and saturating scales
		sc = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
		sh = '{32'hffffffff, 32'h1, 32'h80000000};
		send_pose(16'h7fff, 16'h8000, 16'h5a00, sc, sh, 0);
		send_pose(16'h8000, 16'h7fff, 16'ha600, sc, sh, 1);
		send_pose(16'd1440, 16'd4320, 16'hffff, sc, sh, 0);
		sc = '{32'h0, 32'hffffffff, 32'h80000000};
		send_pose(16'h0, 16'h0, 16'h0, sc, sh, 3);
		// let everything drain before the random phase
		in_valid <= 0;
		while (board.pending_rows.size() != 0)
			@(posedge clk);
		for (int n = 0; n < 470; n++) begin
			foreach (sc[i]) begin
				sc[i] = pick_q16();
				sh[i] = pick_q16();
			end
			send_pose(pick_angle(), pick_angle(), pick_angle(), sc, sh,
				(n % 100 < 30) ? 0 : $urandom_range(0, 17));
			if (n == 250) begin
				in_valid <= 0;
				while (board.pending_rows.size() != 0)
					@(posedge clk);
			end
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// random stall before each row, often none
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 17);
			if ($urandom_range(0, 3) == 0)
				hold = 0;
			if (hold != 0) begin
				out_stall <= 1;
				repeat (hold) @(posedge clk);
				out_stall <= 0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// check each accepted row
	always @(posedge clk) begin
		logic [31:0] e [4];
		if (arst_n && out_valid && !out_stall) begin
			e = '{entry_0, entry_1, entry_2, entry_3};
			board.check_row(row_index, e, last_row);
		end
	end

	// wait for the last rows, then report
	initial begin
		wait (stim_done);
		while (board.pending_rows.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending_rows.size() == 0)
			$display("tb_model_transform_matrix: PASS");
		else
			$display("tb_model_transform_matrix: FAIL");
		$finish;
	end

	initial begin
		#400000;
		$display("tb_model_transform_matrix: FAIL");
		$finish;
	end
endmodule
